### src/cmm_pkg.sv
// Shared types, widths and codes for the cartridge memory mapper.
package cmm_pkg;

	localparam int ROM_ADDR_BITS = 22;
	localparam int RAM_ADDR_BITS = 17;
	localparam int ROM_IDX_W     = 24;
	localparam int RAM_IDX_W     = 19;
	localparam int CFG_ADDR_W    = 2;
	localparam int CFG_DATA_W    = 5;

	localparam logic [1:0] MODE_READ  = 2'd0;
	localparam logic [1:0] MODE_WRITE = 2'd1;
	localparam logic [1:0] MODE_LOAD  = 2'd2;

	localparam logic [1:0] SRC_NONE = 2'd0;
	localparam logic [1:0] SRC_ROM  = 2'd1;
	localparam logic [1:0] SRC_RAM  = 2'd2;

	localparam logic [1:0] MAP_LOROM = 2'd1;
	localparam logic [1:0] MAP_HIROM = 2'd2;

	localparam logic [CFG_ADDR_W-1:0] REG_CART_MAPPING  = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_ROM_SIZE_LOG2 = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_RAM_SIZE_LOG2 = 2'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_RAM_PRESENT   = 2'd3;

	typedef struct packed {
		logic [1:0]  mode;
		logic [7:0]  bank;
		logic [15:0] offset;
		logic [7:0]  write_data;
		logic [21:0] load_index;
		logic [7:0]  open_bus;
	} req_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic [1:0] source;
	} rsp_t;

	typedef struct packed {
		logic [1:0] cart_mapping;
		logic [4:0] rom_size_log2;
		logic [4:0] ram_size_log2;
		logic       ram_present;
	} cfg_t;

	typedef struct packed {
		logic                     we;
		logic                     re;
		logic [ROM_ADDR_BITS-1:0] addr;
		logic [7:0]               wdata;
	} rom_req_t;

	typedef struct packed {
		logic                     we;
		logic                     re;
		logic [RAM_ADDR_BITS-1:0] addr;
		logic [7:0]               wdata;
	} ram_req_t;

	typedef struct packed {
		rom_req_t   rom;
		ram_req_t   ram;
		logic [1:0] src;
		logic [7:0] fallback;
	} access_t;

endpackage

### src/cmm_if.sv
// Handshake channels of the cartridge memory mapper: request, response, configuration.
interface cmm_req_if
	import cmm_pkg::*;
();
	logic valid;
	logic ready;
	req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface cmm_rsp_if
	import cmm_pkg::*;
();
	logic valid;
	logic ready;
	rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface cmm_cfg_if
	import cmm_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic [CFG_ADDR_W-1:0] addr;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output addr, output data, input ready);
	modport sink (input valid, input addr, input data, output ready);
endinterface

### src/cmm_decode.sv
// Address decoder: turns one bus item into ROM and RAM accesses.
module cmm_decode
	import cmm_pkg::*;
(
	input  req_t    req,
	input  cfg_t    cfg,
	output access_t acc
);

	logic [ROM_ADDR_BITS-1:0] rom_mask;
	logic [RAM_ADDR_BITS-1:0] ram_mask;
	logic [ROM_IDX_W-1:0]     rom_idx;
	logic [RAM_IDX_W-1:0]     ram_idx;
	logic [ROM_IDX_W-1:0]     load_idx;
	logic                     lo_ram_win;
	logic                     hi_ram_win;
	logic                     hi_rom_hit;
	logic [1:0]               rd_src;
	logic                     wr_hit;

	always_comb begin
		for (int i = 0; i < ROM_ADDR_BITS; i++) begin
			rom_mask[i] = (5'(i) < cfg.rom_size_log2);
		end
		for (int i = 0; i < RAM_ADDR_BITS; i++) begin
			ram_mask[i] = (5'(i) < cfg.ram_size_log2);
		end
	end

	always_comb begin
		lo_ram_win = ((req.bank >= 8'h70 && req.bank < 8'h7e) || req.bank >= 8'hf0)
			&& !req.offset[15] && cfg.ram_present;
		hi_ram_win = !req.bank[6] && req.offset >= 16'h6000 && req.offset < 16'h8000
			&& cfg.ram_present;
		hi_rom_hit = req.offset[15] || req.bank[6];
		load_idx   = ROM_IDX_W'(req.load_index);

		rd_src  = SRC_NONE;
		wr_hit  = 1'b0;
		rom_idx = '0;
		ram_idx = '0;
		case (cfg.cart_mapping)
			MAP_LOROM: begin
				rom_idx = {1'b0, req.bank, req.offset[14:0]};
				ram_idx = {req.bank[3:0], req.offset[14:0]};
				wr_hit  = lo_ram_win;
				if (req.offset[15]) begin
					rd_src = SRC_ROM;
				end else if (lo_ram_win) begin
					rd_src = SRC_RAM;
				end else if (req.bank[6]) begin
					rd_src = SRC_ROM;
				end
			end
			MAP_HIROM: begin
				rom_idx = {2'b00, req.bank[5:0], req.offset};
				ram_idx = {req.bank[5:0], req.offset[12:0]};
				wr_hit  = hi_ram_win;
				if (hi_ram_win) begin
					rd_src = SRC_RAM;
				end else if (hi_rom_hit) begin
					rd_src = SRC_ROM;
				end
			end
			default: begin
				rd_src = SRC_NONE;
			end
		endcase

		acc.rom.we    = 1'b0;
		acc.rom.re    = 1'b0;
		acc.rom.addr  = rom_idx[ROM_ADDR_BITS-1:0] & rom_mask;
		acc.rom.wdata = req.write_data;
		acc.ram.we    = 1'b0;
		acc.ram.re    = 1'b0;
		acc.ram.addr  = ram_idx[RAM_ADDR_BITS-1:0] & ram_mask;
		acc.ram.wdata = req.write_data;
		acc.src       = SRC_NONE;
		acc.fallback  = '0;

		case (req.mode)
			MODE_READ: begin
				acc.src    = rd_src;
				acc.rom.re = (rd_src == SRC_ROM);
				acc.ram.re = (rd_src == SRC_RAM);
				if (rd_src == SRC_NONE) begin
					acc.fallback = req.open_bus;
				end
			end
			MODE_WRITE: begin
				acc.ram.we = wr_hit;
			end
			MODE_LOAD: begin
				acc.rom.we   = 1'b1;
				acc.rom.addr = load_idx[ROM_ADDR_BITS-1:0];
			end
			default: begin
				acc.src = SRC_NONE;
			end
		endcase
	end

endmodule

### src/cmm_rom.sv
// ROM image store: single-port synchronous memory, loaded by load items.
module cmm_rom
	import cmm_pkg::*;
(
	input  logic       clk,
	input  rom_req_t   req,
	output logic [7:0] rdata
);

	logic [7:0] mem [2**ROM_ADDR_BITS];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.wdata;
		end else if (req.re) begin
			rdata_q <= mem[req.addr];
		end
	end

	assign rdata = rdata_q;

endmodule

### src/cmm_ram.sv
// Cartridge RAM store: single-port synchronous memory with a zeroing sweep after reset.
module cmm_ram
	import cmm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  ram_req_t   req,
	output logic [7:0] rdata,
	output logic       clear_done
);

	logic [7:0]               mem [2**RAM_ADDR_BITS];
	logic [7:0]               rdata_q;
	logic                     clearing_q;
	logic [RAM_ADDR_BITS-1:0] clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (&clr_addr_q) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clearing_q) begin
			mem[clr_addr_q] <= '0;
		end else if (req.we) begin
			mem[req.addr] <= req.wdata;
		end else if (req.re) begin
			rdata_q <= mem[req.addr];
		end
	end

	assign rdata      = rdata_q;
	assign clear_done = !clearing_q;

endmodule

### src/cartridge_memory_mapper.sv
// Cartridge memory mapper top level: config registers, item control and result register.
// Each request item is a bus read, a bus write or a ROM load byte. The address is decoded in
// the accept cycle and the ROM or RAM access is issued at the accept edge; the registered
// memory data is selected into the result register at the next edge, so a result is valid
// once registered. No new item is taken while one is pending or while an untaken result
// is held and not being drained. After reset the RAM is zeroed one entry per cycle over all
// 2**RAM_ADDR_BITS entries (131072); no request item is accepted until that sweep ends,
// while configuration writes are taken at any time. ROM contents survive reset and must be
// loaded before they are read. Configuration must be written only while idle by the user;
// the block does not enforce this.
module cartridge_memory_mapper
	import cmm_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	cmm_cfg_if.sink   cfg,
	cmm_req_if.sink   req,
	cmm_rsp_if.source rsp
);

	cfg_t       cfg_q;
	access_t    dec;
	rom_req_t   rom_req;
	ram_req_t   ram_req;
	logic [7:0] rom_rdata;
	logic [7:0] ram_rdata;
	logic       ram_ready;
	logic       accept;
	logic       pend_q;
	logic [1:0] src_s1;
	logic [7:0] fallback_s1;
	logic       rsp_valid_q;
	rsp_t       rsp_q;
	rsp_t       result;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cart_mapping  <= 2'd0;
			cfg_q.rom_size_log2 <= 5'd22;
			cfg_q.ram_size_log2 <= 5'd13;
			cfg_q.ram_present   <= 1'b1;
		end else if (cfg.valid) begin
			unique case (cfg.addr)
				REG_CART_MAPPING:  cfg_q.cart_mapping  <= cfg.data[1:0];
				REG_ROM_SIZE_LOG2: cfg_q.rom_size_log2 <= cfg.data[4:0];
				REG_RAM_SIZE_LOG2: cfg_q.ram_size_log2 <= cfg.data[4:0];
				REG_RAM_PRESENT:   cfg_q.ram_present   <= cfg.data[0];
			endcase
		end
	end

	cmm_decode u_decode (
		.req (req.data),
		.cfg (cfg_q),
		.acc (dec)
	);

	assign req.ready = ram_ready && !pend_q && (!rsp_valid_q || rsp.ready);
	assign accept    = req.valid && req.ready;

	always_comb begin
		rom_req    = dec.rom;
		rom_req.we = dec.rom.we && accept;
		rom_req.re = dec.rom.re && accept;
		ram_req    = dec.ram;
		ram_req.we = dec.ram.we && accept;
		ram_req.re = dec.ram.re && accept;
	end

	cmm_rom u_rom (
		.clk   (clk),
		.req   (rom_req),
		.rdata (rom_rdata)
	);

	cmm_ram u_ram (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (ram_req),
		.rdata      (ram_rdata),
		.clear_done (ram_ready)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else begin
			pend_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			src_s1      <= dec.src;
			fallback_s1 <= dec.fallback;
		end
	end

	always_comb begin
		result.source = src_s1;
		case (src_s1)
			SRC_ROM: result.read_data = rom_rdata;
			SRC_RAM: result.read_data = ram_rdata;
			default: result.read_data = fallback_s1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (pend_q) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pend_q) begin
			rsp_q <= result;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

endmodule
